// File: src/hsc_pkg.sv
// Package for the heap sort block: shared widths and constants.
// No dependencies.
package hsc_pkg;
    localparam int unsigned MAX_ITEMS_DEF = 64;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 11'd2047;
endpackage

// File: src/heap_sort_with_counts.sv
// Heap sort with comparison and swap totals: collect, heapify, extract, emit.
// Depends on hsc_pkg and hsc_ram.
//
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_stall   | value, final_item
// out     | output    | out_valid/out_stall | sorted_value, last_out, counts, overflowed
//
// Non-final items are accepted back to back while collecting. A final item
// starts the sort on the single-port element RAM: a sift step reads the node and
// its children in turn and, on a swap, writes both back; each extraction swaps
// root and last through S_EXT, S_EXT0, S_EMIT and S_ROOTW. Results then leave
// one at a time, each held under out_stall until it is taken.
// Reset clears the state, item count, totals, flags and loop counters; the RAM needs no clearing.
module heap_sort_with_counts
    import hsc_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [VALUE_W-1:0]   value,
    input  logic                        final_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [VALUE_W-1:0]   sorted_value,
    output logic                        last_out,
    output logic [COUNT_W-1:0]          compare_count,
    output logic [COUNT_W-1:0]          swap_count,
    output logic                        overflowed
);
    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned XW = AW + 2;

    localparam logic [3:0] S_COLLECT = 4'd0;
    localparam logic [3:0] S_BUILD   = 4'd1;
    localparam logic [3:0] S_NODE    = 4'd2;
    localparam logic [3:0] S_LEFT    = 4'd3;
    localparam logic [3:0] S_RIGHT   = 4'd4;
    localparam logic [3:0] S_DECIDE  = 4'd5;
    localparam logic [3:0] S_SWAP2   = 4'd6;
    localparam logic [3:0] S_EXT     = 4'd7;
    localparam logic [3:0] S_EXT0    = 4'd8;
    localparam logic [3:0] S_EXT1    = 4'd9;
    localparam logic [3:0] S_RD      = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;
    localparam logic [3:0] S_ROOTW   = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0]              state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           size_reg, size_next;
    logic [CW-1:0]           iter_reg, iter_next;
    logic                    heapify_reg, heapify_next;
    logic [XW-1:0]           node_reg, node_next;
    logic [XW-1:0]           top_reg, top_next;
    logic [VALUE_W-1:0]      nval_reg, nval_next;
    logic [VALUE_W-1:0]      tval_reg, tval_next;
    logic [COUNT_W-1:0]      cmp_reg, cmp_next;
    logic [COUNT_W-1:0]      swp_reg, swp_next;
    logic                    ovf_reg, ovf_next;
    logic [CW-1:0]           k_reg, k_next;
    logic                    ov_reg, ov_next;
    logic [VALUE_W-1:0]      ovd_reg, ovd_next;
    logic                    olast_reg, olast_next;

    logic                    we;
    logic [AW-1:0]           addr;
    logic [VALUE_W-1:0]      wdata, rdata;

    hsc_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    function automatic logic [COUNT_W-1:0] sat_add(logic [COUNT_W-1:0] a,
                                                   logic [1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {{(COUNT_W-1){1'b0}}, b};
        return s[COUNT_W] ? COUNT_LIMIT : s[COUNT_W-1:0];
    endfunction

    function automatic logic gt(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

    logic [XW-1:0] left_w, right_w;
    assign left_w  = {node_reg[XW-2:0], 1'b1};
    assign right_w = left_w + XW'(1);

    assign in_stall     = (state_reg != S_COLLECT);
    assign out_valid    = ov_reg;
    assign sorted_value = ovd_reg;
    assign last_out     = olast_reg;
    assign compare_count = cmp_reg;
    assign swap_count   = swp_reg;
    assign overflowed   = ovf_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        size_next    = size_reg;
        iter_next    = iter_reg;
        heapify_next = heapify_reg;
        node_next    = node_reg;
        top_next     = top_reg;
        nval_next    = nval_reg;
        tval_next    = tval_reg;
        cmp_next     = cmp_reg;
        swp_next     = swp_reg;
        ovf_next     = ovf_reg;
        k_next       = k_reg;
        ov_next      = ov_reg;
        ovd_next     = ovd_reg;
        olast_next   = olast_reg;
        we           = 1'b0;
        addr         = '0;
        wdata        = nval_reg;
        unique case (state_reg)
            S_COLLECT:
            begin
                if (in_valid)
                begin
                    addr  = count_reg[AW-1:0];
                    wdata = value;
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (final_item)
                    begin
                        cmp_next     = '0;
                        swp_next     = '0;
                        heapify_next = 1'b1;
                        iter_next    = (count_reg < CW'(MAX_ITEMS))
                                       ? CW'((count_reg + CW'(1)) >> 1)
                                       : CW'(count_reg >> 1);
                        state_next   = S_BUILD;
                    end
                end
            end
            S_BUILD:
            begin
                size_next = count_reg;
                if (iter_reg == '0)
                begin
                    heapify_next = 1'b0;
                    iter_next    = count_reg;
                    state_next   = S_EXT;
                end
                else
                begin
                    node_next  = XW'(iter_reg - CW'(1));
                    iter_next  = iter_reg - CW'(1);
                    state_next = S_NODE;
                end
            end
            S_NODE:
            begin
                addr       = node_reg[AW-1:0];
                cmp_next   = sat_add(cmp_reg, 2'd2);
                top_next   = node_reg;
                state_next = S_LEFT;
            end
            S_LEFT:
            begin
                nval_next = rdata;
                tval_next = rdata;
                addr      = left_w[AW-1:0];
                if (left_w < XW'(size_reg))
                    state_next = S_RIGHT;
                else
                    state_next = heapify_reg ? S_BUILD : S_EXT;
            end
            S_RIGHT:
            begin
                if (gt(rdata, tval_reg))
                begin
                    tval_next = rdata;
                    top_next  = left_w;
                end
                addr = right_w[AW-1:0];
                if (right_w < XW'(size_reg))
                    state_next = S_DECIDE;
                else
                    state_next = S_SWAP2;
            end
            S_DECIDE:
            begin
                if (gt(rdata, tval_reg))
                begin
                    tval_next = rdata;
                    top_next  = right_w;
                end
                state_next = S_SWAP2;
            end
            S_SWAP2:
            begin
                if (top_reg == node_reg)
                begin
                    state_next = heapify_reg ? S_BUILD : S_EXT;
                end
                else
                begin
                    we         = 1'b1;
                    addr       = node_reg[AW-1:0];
                    wdata      = tval_reg;
                    swp_next   = sat_add(swp_reg, 2'd1);
                    node_next  = top_reg;
                    state_next = S_EXT1;
                end
            end
            S_EXT1:
            begin
                // write the old parent value into the child, continue sifting
                we         = 1'b1;
                addr       = node_reg[AW-1:0];
                wdata      = nval_reg;
                state_next = S_NODE;
            end
            S_EXT:
            begin
                if (iter_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_RD;
                end
                else
                begin
                    addr       = '0;
                    swp_next   = sat_add(swp_reg, 2'd1);
                    state_next = S_EXT0;
                end
            end
            S_EXT0:
            begin
                // rdata is root; read last
                tval_next  = rdata;
                addr       = AW'(iter_reg - CW'(1));
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // extraction swap: last <- old root, then root <- old last
                we         = 1'b1;
                addr       = AW'(iter_reg - CW'(1));
                wdata      = tval_reg;
                nval_next  = rdata;
                size_next  = iter_reg - CW'(1);
                iter_next  = iter_reg - CW'(1);
                state_next = S_ROOTW;
            end
            S_ROOTW:
            begin
                we         = 1'b1;
                addr       = '0;
                wdata      = nval_reg;
                node_next  = '0;
                state_next = S_NODE;
            end
            S_RD:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b0;
                    if (k_reg == count_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        addr       = k_reg[AW-1:0];
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                ovd_next   = rdata;
                olast_next = (k_reg + CW'(1) == count_reg);
                k_next     = k_reg + CW'(1);
                state_next = S_RD;
            end
            S_DONE:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                cmp_next   = '0;
                swp_next   = '0;
                state_next = S_COLLECT;
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_COLLECT;
            count_reg   <= '0;
            cmp_reg     <= '0;
            swp_reg     <= '0;
            ovf_reg     <= 1'b0;
            ov_reg      <= 1'b0;
            heapify_reg <= 1'b0;
            iter_reg    <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_reg     <= cmp_next;
            swp_reg     <= swp_next;
            ovf_reg     <= ovf_next;
            ov_reg      <= ov_next;
            heapify_reg <= heapify_next;
            iter_reg    <= iter_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg  <= size_next;
        node_reg  <= node_next;
        top_reg   <= top_next;
        nval_reg  <= nval_next;
        tval_reg  <= tval_next;
        ovd_reg   <= ovd_next;
        olast_reg <= olast_next;
    end

    a_no_in_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_COLLECT) |-> in_stall)
        else $error("input taken while sorting");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("item count past capacity");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(ovd_reg)))
        else $error("stalled result changed");
endmodule

// File: src/hsc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module hsc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: bench/tb_heap_sort_with_counts.sv
// Self-checking testbench for heap_sort_with_counts: arrays of signed values are
// sorted by a local max-heap predictor and checked against the block's results.
// Depends on hsc_pkg and the heap_sort_with_counts RTL.
module tb_heap_sort_with_counts;
    timeunit 1ns;
    timeprecision 1ps;
    import hsc_pkg::*;

    localparam int unsigned CAP = MAX_ITEMS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      final_item;
    } elem_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic [COUNT_W-1:0]        compare_count;
        logic [COUNT_W-1:0]        swap_count;
        logic                      overflowed;
    } sorted_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [VALUE_W-1:0] value;
    logic final_item;
    logic out_valid;
    logic out_stall;
    logic signed [VALUE_W-1:0] sorted_value;
    logic last_out;
    logic [COUNT_W-1:0] compare_count;
    logic [COUNT_W-1:0] swap_count;
    logic overflowed;

    elem_t   pending_elems[$];
    sorted_t expected_sorted[$];
    int      error_count;
    int      idle_cycles;
    int      burst_left;
    int      gap_left;
    int      finals_sent;
    bit      hold_until_drained;
    bit      stim_done;

    logic signed [VALUE_W-1:0] heap_store[CAP];
    int unsigned heap_fill;
    int unsigned cmp_total;
    int unsigned swp_total;
    bit          dropped;

    heap_sort_with_counts u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .value(value), .final_item(final_item),
        .out_valid(out_valid), .out_stall(out_stall),
        .sorted_value(sorted_value), .last_out(last_out),
        .compare_count(compare_count), .swap_count(swap_count),
        .overflowed(overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned sat_add(int unsigned acc, int unsigned amount);
        return (acc + amount > COUNT_LIMIT) ? COUNT_LIMIT : acc + amount;
    endfunction

    function automatic void sift_heap(int unsigned size, int unsigned node);
        int unsigned top;
        int unsigned left;
        int unsigned right;
        logic signed [VALUE_W-1:0] tmp;
        forever
        begin
            top = node;
            left = 2 * node + 1;
            right = 2 * node + 2;
            cmp_total = sat_add(cmp_total, 2);
            if (left < size && heap_store[left] > heap_store[top])
                top = left;
            if (right < size && heap_store[right] > heap_store[top])
                top = right;
            if (top == node)
                return;
            swp_total = sat_add(swp_total, 1);
            tmp = heap_store[node];
            heap_store[node] = heap_store[top];
            heap_store[top] = tmp;
            node = top;
        end
    endfunction

    function automatic void predict_sort(elem_t e);
        logic signed [VALUE_W-1:0] tmp;
        sorted_t r;
        if (heap_fill < CAP)
        begin
            heap_store[heap_fill] = e.value;
            heap_fill++;
        end
        else
            dropped = 1'b1;
        if (!e.final_item)
            return;
        for (int unsigned i = heap_fill / 2; i > 0; i--)
            sift_heap(heap_fill, i - 1);
        for (int unsigned i = heap_fill; i > 0; i--)
        begin
            swp_total = sat_add(swp_total, 1);
            tmp = heap_store[i - 1];
            heap_store[i - 1] = heap_store[0];
            heap_store[0] = tmp;
            sift_heap(i - 1, 0);
        end
        for (int unsigned k = 0; k < heap_fill; k++)
        begin
            r.sorted_value = heap_store[k];
            r.last_out = (k + 1 == heap_fill);
            r.compare_count = cmp_total[COUNT_W-1:0];
            r.swap_count = swp_total[COUNT_W-1:0];
            r.overflowed = dropped;
            expected_sorted.push_back(r);
        end
        heap_fill = 0;
        cmp_total = 0;
        swp_total = 0;
        dropped = 1'b0;
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 7)) - 32'd3);
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic queue_array(int unsigned len, bit few_values);
        elem_t e;
        for (int unsigned i = 0; i < len; i++)
        begin
            e.value = few_values ? $signed(32'($urandom_range(0, 3))) : rand_value();
            e.final_item = (i + 1 == len);
            pending_elems.push_back(e);
        end
    endtask

    initial
    begin
        elem_t e;
        int unsigned queued;
        rst_n = 1'b0;
        heap_fill = 0;
        cmp_total = 0;
        swp_total = 0;
        dropped = 1'b0;
        stim_done = 1'b0;
        // single element, then extremes and duplicates
        e.value = 32'sh7fffffff; e.final_item = 1'b1; pending_elems.push_back(e);
        e.value = 32'sh7fffffff; e.final_item = 1'b0; pending_elems.push_back(e);
        e.value = 32'sh80000000; e.final_item = 1'b0; pending_elems.push_back(e);
        e.value = -32'sd1;       e.final_item = 1'b0; pending_elems.push_back(e);
        e.value = 32'sd0;        e.final_item = 1'b0; pending_elems.push_back(e);
        e.value = 32'sh55555555; e.final_item = 1'b0; pending_elems.push_back(e);
        e.value = 32'shaaaaaaaa; e.final_item = 1'b0; pending_elems.push_back(e);
        e.value = 32'sh80000000; e.final_item = 1'b1; pending_elems.push_back(e);
        queue_array(2, 1'b1);
        queue_array(5, 1'b1);
        queued = 0;
        while (queued < 150)
        begin
            automatic int unsigned len = ($urandom_range(0, 9) == 0)
                ? $urandom_range(60, 70) : $urandom_range(1, 12);
            queue_array(len, $urandom_range(0, 3) == 0);
            queued += len;
        end
        // full store plus dropped items, with the final one dropped too
        queue_array(CAP + 3, 1'b0);
        stim_done = 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value <= '0;
            final_item <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
            finals_sent <= 0;
            hold_until_drained <= 1'b1;
        end
        else if (!(in_valid && in_stall))
        begin
            automatic bit sent = in_valid;
            automatic bit go = 1'b0;
            if (sent)
                predict_sort('{value: value, final_item: final_item});
            if (sent && final_item)
                finals_sent <= finals_sent + 1;
            if (sent && final_item && (finals_sent % 5 == 1 || $urandom_range(0, 7) == 0))
                hold_until_drained <= 1'b1;
            if (hold_until_drained && !(sent && final_item))
            begin
                if (expected_sorted.size() == 0 && !out_valid)
                    hold_until_drained <= 1'b0;
            end
            else if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_elems.size() > 0)
            begin
                go = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            if (sent && final_item)
                go = 1'b0;
            if (go)
            begin
                automatic elem_t nxt = pending_elems.pop_front();
                in_valid <= 1'b1;
                value <= nxt.value;
                final_item <= nxt.final_item;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            automatic int unsigned phase = int'(($time / 2000) % 4);
            out_stall <= (phase == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_count <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_sorted.size() == 0)
                begin
                    $error("unexpected transfer: sorted_value %0d", sorted_value);
                    error_count <= error_count + 1;
                end
                else
                begin
                    automatic sorted_t exp = expected_sorted.pop_front();
                    automatic int bad = 0;
                    if (sorted_value !== exp.sorted_value)
                    begin
                        $error("sorted_value: expected %0d, got %0d",
                            exp.sorted_value, sorted_value);
                        bad++;
                    end
                    if (last_out !== exp.last_out)
                    begin
                        $error("last_out: expected %0d, got %0d", exp.last_out, last_out);
                        bad++;
                    end
                    if (compare_count !== exp.compare_count)
                    begin
                        $error("compare_count: expected %0d, got %0d",
                            exp.compare_count, compare_count);
                        bad++;
                    end
                    if (swap_count !== exp.swap_count)
                    begin
                        $error("swap_count: expected %0d, got %0d",
                            exp.swap_count, swap_count);
                        bad++;
                    end
                    if (overflowed !== exp.overflowed)
                    begin
                        $error("overflowed: expected %0d, got %0d",
                            exp.overflowed, overflowed);
                        bad++;
                    end
                    error_count <= error_count + bad;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        while (pending_elems.size() > 0 || in_valid || expected_sorted.size() > 0)
        begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
                break;
        end
        if (idle_cycles < WATCHDOG_LIMIT)
            repeat (50) @(posedge clk);
        if (idle_cycles >= WATCHDOG_LIMIT)
            $display("FAILED: results differ");
        else if (error_count == 0 && expected_sorted.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
